@@ rtl/core/l2l_pkg.sv @@
// shared constants, control struct and arctangent table for the lab to lch converter
package l2l_pkg;

	localparam int unsigned DEF_ITERATIONS      = 16;
	localparam int unsigned DEF_COMPONENT_WIDTH = 16;
	localparam int unsigned MAX_ITER            = 24;
	localparam int unsigned PRE_SHIFT           = 16;
	localparam int unsigned HUE_W               = 16;
	localparam int unsigned TURN_W              = 32;

	localparam logic [TURN_W-1:0] HALF_TURN  = 32'h8000_0000;
	localparam logic [TURN_W-1:0] HUE_ROUND  = 32'h0000_8000;

	// control bits that move with every sample
	typedef struct packed {
		logic valid;
		logic zero;
	} l2l_ctl_t;

	// atan(2^-i) as a fraction of a full turn, scaled by 2^32
	function automatic logic [TURN_W-1:0] turn_atan(input int unsigned i);
		logic [TURN_W-1:0] r;
		unique case (i)
			0:       r = 32'h2000_0000;
			1:       r = 32'h12E4_051E;
			2:       r = 32'h09FB_385B;
			3:       r = 32'h0511_11D4;
			4:       r = 32'h028B_0D43;
			5:       r = 32'h0145_D7E1;
			6:       r = 32'h00A2_F61E;
			7:       r = 32'h0051_7C55;
			8:       r = 32'h0028_BE53;
			9:       r = 32'h0014_5F2F;
			10:      r = 32'h000A_2F98;
			11:      r = 32'h0005_17CC;
			12:      r = 32'h0002_8BE6;
			13:      r = 32'h0001_45F3;
			14:      r = 32'h0000_A2FA;
			15:      r = 32'h0000_517D;
			16:      r = 32'h0000_28BE;
			17:      r = 32'h0000_145F;
			18:      r = 32'h0000_0A30;
			19:      r = 32'h0000_0518;
			20:      r = 32'h0000_028C;
			21:      r = 32'h0000_0146;
			22:      r = 32'h0000_00A3;
			23:      r = 32'h0000_0051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/l2l_prep.sv @@
// input conditioning: half-plane fold, squares and their sum over two register stages
module l2l_prep #(
	parameter int unsigned W = l2l_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       en,
	input  logic                                       in_valid,
	input  logic [W-1:0]                               light_in,
	input  logic [W-1:0]                               a_in,
	input  logic [W-1:0]                               b_in,
	output l2l_pkg::l2l_ctl_t                          ctl_out,
	output logic [W-1:0]                               light_out,
	output logic signed [W+l2l_pkg::PRE_SHIFT+1:0]    x_out,
	output logic signed [W+l2l_pkg::PRE_SHIFT+1:0]    y_out,
	output logic [l2l_pkg::TURN_W-1:0]                 z_out,
	output logic [2*W-1:0]                             sum_out
);
	import l2l_pkg::*;

	localparam int unsigned XW = W + PRE_SHIFT + 2;

	logic signed [W-1:0]   a_sgn;
	logic signed [W-1:0]   b_sgn;
	logic signed [XW-1:0]  a_ext;
	logic signed [XW-1:0]  b_ext;
	logic signed [2*W-1:0] a_prod;
	logic signed [2*W-1:0] b_prod;
	logic                  neg;

	l2l_ctl_t              ctl_s1;
	logic [W-1:0]          light_s1;
	logic signed [XW-1:0]  x_s1;
	logic signed [XW-1:0]  y_s1;
	logic [TURN_W-1:0]     z_s1;
	logic [2*W-2:0]        a_sq_s1;
	logic [2*W-2:0]        b_sq_s1;

	l2l_ctl_t              ctl_s2;
	logic [W-1:0]          light_s2;
	logic signed [XW-1:0]  x_s2;
	logic signed [XW-1:0]  y_s2;
	logic [TURN_W-1:0]     z_s2;
	logic [2*W-1:0]        sum_s2;

	always_comb begin
		a_sgn  = a_in;
		b_sgn  = b_in;
		a_ext  = {{(XW-W){a_in[W-1]}}, a_in};
		b_ext  = {{(XW-W){b_in[W-1]}}, b_in};
		neg    = a_in[W-1];
		a_prod = a_sgn * a_sgn;
		b_prod = b_sgn * b_sgn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.zero  <= (a_in == '0) && (b_in == '0);
			ctl_s2       <= ctl_s1;
		end
	end

	// left half plane: turn by half a turn before the rotations
	always_ff @(posedge clk) begin
		if (en) begin
			light_s1 <= light_in;
			x_s1     <= (neg ? -a_ext : a_ext) <<< PRE_SHIFT;
			y_s1     <= (neg ? -b_ext : b_ext) <<< PRE_SHIFT;
			z_s1     <= neg ? HALF_TURN : '0;
			a_sq_s1  <= a_prod[2*W-2:0];
			b_sq_s1  <= b_prod[2*W-2:0];
			light_s2 <= light_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
			sum_s2   <= {1'b0, a_sq_s1} + {1'b0, b_sq_s1};
		end
	end

	assign ctl_out   = ctl_s2;
	assign light_out = light_s2;
	assign x_out     = x_s2;
	assign y_out     = y_s2;
	assign z_out     = z_s2;
	assign sum_out   = sum_s2;

endmodule

@@ rtl/core/l2l_stage.sv @@
// one pipeline step: a cordic micro-rotation and one digit of the square root
module l2l_stage #(
	parameter int unsigned W   = l2l_pkg::DEF_COMPONENT_WIDTH,
	parameter int unsigned N   = l2l_pkg::DEF_ITERATIONS,
	parameter int unsigned IDX = 0
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  l2l_pkg::l2l_ctl_t                        ctl_in,
	input  logic [W-1:0]                             light_in,
	input  logic signed [W+l2l_pkg::PRE_SHIFT+1:0]  x_in,
	input  logic signed [W+l2l_pkg::PRE_SHIFT+1:0]  y_in,
	input  logic [l2l_pkg::TURN_W-1:0]               z_in,
	input  logic [2*W-1:0]                           rad_in,
	input  logic [W:0]                               rem_in,
	input  logic [W-1:0]                             root_in,
	output l2l_pkg::l2l_ctl_t                        ctl_out,
	output logic [W-1:0]                             light_out,
	output logic signed [W+l2l_pkg::PRE_SHIFT+1:0]  x_out,
	output logic signed [W+l2l_pkg::PRE_SHIFT+1:0]  y_out,
	output logic [l2l_pkg::TURN_W-1:0]               z_out,
	output logic [2*W-1:0]                           rad_out,
	output logic [W:0]                               rem_out,
	output logic [W-1:0]                             root_out
);
	import l2l_pkg::*;

	localparam int unsigned       XW   = W + PRE_SHIFT + 2;
	localparam logic [TURN_W-1:0] ATAN = turn_atan(IDX);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [XW-1:0] x_nx;
	logic signed [XW-1:0] y_nx;
	logic [TURN_W-1:0]    z_nx;
	logic [W+2:0]         trial;
	logic [W+2:0]         tq;
	logic [W+2:0]         diff;
	logic [2*W-1:0]       rad_nx;
	logic [W:0]           rem_nx;
	logic [W-1:0]         root_nx;

	l2l_ctl_t             ctl_sn;
	logic [W-1:0]         light_sn;
	logic signed [XW-1:0] x_sn;
	logic signed [XW-1:0] y_sn;
	logic [TURN_W-1:0]    z_sn;
	logic [2*W-1:0]       rad_sn;
	logic [W:0]           rem_sn;
	logic [W-1:0]         root_sn;

	always_comb begin
		xs      = x_in >>> IDX;
		ys      = y_in >>> IDX;
		trial   = {rem_in, rad_in[2*W-1:2*W-2]};
		tq      = {1'b0, root_in, 2'b01};
		diff    = trial - tq;
		x_nx    = x_in;
		y_nx    = y_in;
		z_nx    = z_in;
		rad_nx  = rad_in;
		rem_nx  = rem_in;
		root_nx = root_in;
		// rotate towards the positive x axis
		if (IDX < N) begin
			if (!y_in[XW-1]) begin
				x_nx = x_in + ys;
				y_nx = y_in - xs;
				z_nx = z_in + ATAN;
			end else begin
				x_nx = x_in - ys;
				y_nx = y_in + xs;
				z_nx = z_in - ATAN;
			end
		end
		// restoring root digit, two radicand bits a step
		if (IDX < W) begin
			rad_nx = {rad_in[2*W-3:0], 2'b00};
			if (trial >= tq) begin
				rem_nx  = diff[W:0];
				root_nx = {root_in[W-2:0], 1'b1};
			end else begin
				rem_nx  = trial[W:0];
				root_nx = {root_in[W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sn <= '0;
		end else if (en) begin
			ctl_sn <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			light_sn <= light_in;
			x_sn     <= x_nx;
			y_sn     <= y_nx;
			z_sn     <= z_nx;
			rad_sn   <= rad_nx;
			rem_sn   <= rem_nx;
			root_sn  <= root_nx;
		end
	end

	assign ctl_out   = ctl_sn;
	assign light_out = light_sn;
	assign x_out     = x_sn;
	assign y_out     = y_sn;
	assign z_out     = z_sn;
	assign rad_out   = rad_sn;
	assign rem_out   = rem_sn;
	assign root_out  = root_sn;

endmodule

@@ rtl/core/l2l_out.sv @@
// final rounding of chroma and hue into the output register
module l2l_out #(
	parameter int unsigned W = l2l_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  l2l_pkg::l2l_ctl_t                 ctl_in,
	input  logic [W-1:0]                      light_in,
	input  logic [l2l_pkg::TURN_W-1:0]        z_in,
	input  logic [W:0]                        rem_in,
	input  logic [W-1:0]                      root_in,
	output logic                              out_valid,
	output logic [W-1:0]                      light_out,
	output logic [W-1:0]                      chroma_out,
	output logic [l2l_pkg::HUE_W-1:0]         hue_out
);
	import l2l_pkg::*;

	logic [TURN_W-1:0] z_rnd;
	logic              up;

	logic              valid_q;
	logic [W-1:0]      light_q;
	logic [W-1:0]      chroma_q;
	logic [HUE_W-1:0]  hue_q;

	always_comb begin
		z_rnd = z_in + HUE_ROUND;
		// round to nearest: remainder above the root means the upper neighbour is closer
		up    = rem_in > {1'b0, root_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			light_q  <= light_in;
			chroma_q <= root_in + W'(up);
			hue_q    <= ctl_in.zero ? '0 : z_rnd[TURN_W-1:TURN_W-HUE_W];
		end
	end

	assign out_valid  = valid_q;
	assign light_out  = light_q;
	assign chroma_out = chroma_q;
	assign hue_out    = hue_q;

endmodule

@@ rtl/core/lab_to_lch_converter.sv @@
// Lab to LCh converter top level: stream ports, conditioning, cordic and root pipeline, output
// One sample is taken every clock unless the output stalls, and each gives one result. From
// input transfer to the output a sample passes two conditioning stages (squares, then their
// sum), one stage per cordic micro-rotation and root digit running side by side, and the
// rounding output register. The whole pipeline advances together, so s_axis_tready is low
// only while a result sits on the output and is not taken.
// Hue is atan2(b, a) as an unsigned fraction of a full turn; a zero vector gives hue 0.
module lab_to_lch_converter #(
	parameter int unsigned CORDIC_ITERATIONS = l2l_pkg::DEF_ITERATIONS,
	parameter int unsigned COMPONENT_WIDTH   = l2l_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic                                                      clk,
	input  logic                                                      arst_n,
	input  logic                                                      s_axis_tvalid,
	output logic                                                      s_axis_tready,
	// lightness_in, a_component, b_component
	input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]                    s_axis_tdata,
	output logic                                                      m_axis_tvalid,
	input  logic                                                      m_axis_tready,
	// lightness_out, chroma, hue_angle
	output logic [((2*COMPONENT_WIDTH+l2l_pkg::HUE_W+7)/8)*8-1:0]     m_axis_tdata
);
	import l2l_pkg::*;

	localparam int unsigned W  = COMPONENT_WIDTH;
	localparam int unsigned N  = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;
	localparam int unsigned D  = (N > W) ? N : W;
	localparam int unsigned XW = W + PRE_SHIFT + 2;

	logic                 en;

	l2l_ctl_t             ctl_st   [D+1];
	logic [W-1:0]         light_st [D+1];
	logic signed [XW-1:0] x_st     [D+1];
	logic signed [XW-1:0] y_st     [D+1];
	logic [TURN_W-1:0]    z_st     [D+1];
	logic [2*W-1:0]       rad_st   [D+1];
	logic [W:0]           rem_st   [D+1];
	logic [W-1:0]         root_st  [D+1];

	logic [W-1:0]         light_o;
	logic [W-1:0]         chroma_o;
	logic [HUE_W-1:0]     hue_o;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	l2l_prep #(
		.W(W)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.light_in  (s_axis_tdata[W-1:0]),
		.a_in      (s_axis_tdata[2*W-1:W]),
		.b_in      (s_axis_tdata[3*W-1:2*W]),
		.ctl_out   (ctl_st[0]),
		.light_out (light_st[0]),
		.x_out     (x_st[0]),
		.y_out     (y_st[0]),
		.z_out     (z_st[0]),
		.sum_out   (rad_st[0])
	);

	assign rem_st[0]  = '0;
	assign root_st[0] = '0;

	for (genvar k = 0; k < D; k++) begin : g_stage
		l2l_stage #(
			.W   (W),
			.N   (N),
			.IDX (k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.ctl_in    (ctl_st[k]),
			.light_in  (light_st[k]),
			.x_in      (x_st[k]),
			.y_in      (y_st[k]),
			.z_in      (z_st[k]),
			.rad_in    (rad_st[k]),
			.rem_in    (rem_st[k]),
			.root_in   (root_st[k]),
			.ctl_out   (ctl_st[k+1]),
			.light_out (light_st[k+1]),
			.x_out     (x_st[k+1]),
			.y_out     (y_st[k+1]),
			.z_out     (z_st[k+1]),
			.rad_out   (rad_st[k+1]),
			.rem_out   (rem_st[k+1]),
			.root_out  (root_st[k+1])
		);
	end

	l2l_out #(
		.W(W)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_in     (ctl_st[D]),
		.light_in   (light_st[D]),
		.z_in       (z_st[D]),
		.rem_in     (rem_st[D]),
		.root_in    (root_st[D]),
		.out_valid  (m_axis_tvalid),
		.light_out  (light_o),
		.chroma_out (chroma_o),
		.hue_out    (hue_o)
	);

	always_comb begin
		m_axis_tdata                    = '0;
		m_axis_tdata[W-1:0]             = light_o;
		m_axis_tdata[2*W-1:W]           = chroma_o;
		m_axis_tdata[2*W+HUE_W-1:2*W]   = hue_o;
	end

`ifndef SYNTHESIS
	// a sample leaving the last stage lands in the output register
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_st[D].valid |=> m_axis_tvalid)
		else $error("sample from last stage lost");

	// a stalled pipeline keeps its occupancy
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ctl_st[0].valid) && $stable(ctl_st[D].valid))
		else $error("pipeline moved during stall");

	// zero chroma only comes from the zero vector, which has hue 0
	a_zero_hue: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (chroma_o == '0) |-> (hue_o == '0))
		else $error("zero vector with non-zero hue");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the lab to lch converter: scoreboard, stream drivers and checks
module tb_top;

	localparam int unsigned CORDIC_STEPS = l2l_pkg::DEF_ITERATIONS;
	localparam int unsigned COMP_W       = l2l_pkg::DEF_COMPONENT_WIDTH;
	localparam int          PIPE_LATENCY = 19;
	localparam int          RANDOM_ITEMS = 1400;
	localparam int          IDLE_PCT     = 27;
	localparam int          HOLD_OFF     = 300;
	localparam int          CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [15:0] hue;
		logic [15:0] chroma;
		logic [15:0] light;
	} lch_t;

	class lch_scoreboard;
		lch_t        expected_lch[$];
		int          errors;
		logic [31:0] atan_turn [0:23];

		function new();
			errors = 0;
			atan_turn = '{
				32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
				32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
				32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
				32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
				32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
				32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051};
		endfunction

		function lch_t polar_of(logic [15:0] light, logic [15:0] a_raw, logic [15:0] b_raw);
			longint          a, b, x, y, xs, ys;
			longint unsigned sq, rem, root, probe;
			logic [31:0]     z;
			logic [32:0]     rounded;
			lch_t            r;
			a = $signed(a_raw);
			b = $signed(b_raw);
			r.light = light;
			// chroma: integer root, rounded to nearest
			sq = longint'(a * a + b * b);
			rem = sq;
			root = 0;
			probe = 64'd1 << 62;
			while (probe > rem)
				probe = probe >> 2;
			while (probe != 0) begin
				if (rem >= root + probe) begin
					rem = rem - (root + probe);
					root = (root >> 1) + probe;
				end else begin
					root = root >> 1;
				end
				probe = probe >> 2;
			end
			if (sq - root * root > root)
				root = root + 1;
			r.chroma = root[15:0];
			r.hue = '0;
			if (a != 0 || b != 0) begin
				x = a;
				y = b;
				z = '0;
				// left half plane: turn by half a turn first
				if (x < 0) begin
					x = -x;
					y = -y;
					z = l2l_pkg::HALF_TURN;
				end
				x = x * 65536;
				y = y * 65536;
				for (int i = 0; i < CORDIC_STEPS; i++) begin
					xs = x >>> i;
					ys = y >>> i;
					if (y >= 0) begin
						x = x + ys;
						y = y - xs;
						z = z + atan_turn[i];
					end else begin
						x = x - ys;
						y = y + xs;
						z = z - atan_turn[i];
					end
				end
				// a full turn after rounding wraps to zero
				rounded = {1'b0, z} + 33'h0_0000_8000;
				r.hue = rounded[31:16];
			end
			return r;
		endfunction

		function void note_sample(logic [15:0] light, logic [15:0] a_raw, logic [15:0] b_raw);
			expected_lch.push_back(polar_of(light, a_raw, b_raw));
		endfunction

		function void check_result(logic [47:0] word);
			lch_t want;
			lch_t got;
			got = word;
			if (expected_lch.size() == 0) begin
				$error("unexpected result transfer: %h", word);
				errors++;
				return;
			end
			want = expected_lch.pop_front();
			if (got.light !== want.light) begin
				$error("lightness_out: expected %0d, actual %0d", want.light, got.light);
				errors++;
			end
			if (got.chroma !== want.chroma) begin
				$error("chroma: expected %0d, actual %0d", want.chroma, got.chroma);
				errors++;
			end
			if (got.hue !== want.hue) begin
				$error("hue_angle: expected %0d, actual %0d", want.hue, got.hue);
				errors++;
			end
		endfunction

		function int pending();
			return expected_lch.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	lch_scoreboard sb;
	int            sent_count = 0;
	int            cycle_count = 0;
	bit            hold_done = 1'b0;

	lab_to_lch_converter #(
		.CORDIC_ITERATIONS(CORDIC_STEPS),
		.COMPONENT_WIDTH(COMP_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stretch of the run with no idling on either side
	function automatic bit calm();
		return sent_count >= 200 && sent_count < 450;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_sample(input logic [15:0] light, input logic [15:0] a_raw,
			input logic [15:0] b_raw);
		while (!calm() && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b_raw, a_raw, light};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_sample(light, a_raw, b_raw);
		sent_count++;
		@(negedge clk);
	endtask

	// receiver side, with one long hold-off while the sender keeps offering
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && sent_count >= 700) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm() || $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] light, a_raw, b_raw, tmp;
		int          pick;
		sb = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero vector, extremes, axes, both half planes, wrap to zero
		send_sample(16'h0000, 16'h0000, 16'h0000);
		send_sample(16'hFFFF, 16'h7FFF, 16'h7FFF);
		send_sample(16'h1234, 16'h8000, 16'h8000);
		send_sample(16'h0000, 16'h8000, 16'h0000);
		send_sample(16'h8000, 16'hFFFF, 16'h0000);
		send_sample(16'h0001, 16'h0001, 16'h0000);
		send_sample(16'h00FF, 16'h0000, 16'h7FFF);
		send_sample(16'hFF00, 16'h0000, 16'h8000);
		send_sample(16'hAAAA, 16'h7FFF, 16'hFFFF);
		send_sample(16'h5555, 16'h8000, 16'h0001);
		send_sample(16'h0F0F, 16'hFFFF, 16'hFFFF);
		send_sample(16'hF0F0, 16'h0001, 16'hFFFF);
		send_sample(16'h7FFF, 16'h7FFF, 16'h8000);
		send_sample(16'h0100, 16'h0100, 16'h0100);
		send_sample(16'hFFFF, 16'h0000, 16'h0001);
		send_sample(16'h0000, 16'h0000, 16'hFFFF);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// sender pause: let the pipeline drain completely
			if (n == 1000) begin
				s_axis_tvalid <= 1'b0;
				while (sb.pending() != 0)
					@(negedge clk);
			end
			light = 16'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				a_raw = 16'($urandom);
				b_raw = 16'($urandom);
			end else if (pick < 85) begin
				a_raw = 16'($urandom_range(0, 128)) - 16'd64;
				b_raw = 16'($urandom_range(0, 128)) - 16'd64;
			end else begin
				// near an axis, where rounding and the half turn matter
				a_raw = 16'($urandom);
				b_raw = 16'($urandom_range(0, 2)) - 16'd1;
				if ($urandom_range(0, 1) == 1) begin
					tmp = a_raw;
					a_raw = b_raw;
					b_raw = tmp;
				end
			end
			send_sample(light, a_raw, b_raw);
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(negedge clk);
		repeat (2 * PIPE_LATENCY) @(negedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ lab_to_lch_converter.f @@
rtl/core/l2l_pkg.sv
rtl/core/l2l_prep.sv
rtl/core/l2l_stage.sv
rtl/core/l2l_out.sv
rtl/core/lab_to_lch_converter.sv
tb/sv/tb_top.sv
